// ===== rtl/fuel_gauge_soc_and_status_top_macros.svh =====
// assertion helpers shared by the gauge rtl
`ifndef FUEL_GAUGE_SOC_AND_STATUS_TOP_MACROS_SVH
`define FUEL_GAUGE_SOC_AND_STATUS_TOP_MACROS_SVH

// same-cycle implication
`define FGS_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FGS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/fgs_pkg.sv =====
package fgs_pkg;

	localparam int VOLT_W = 23;
	localparam int PCT_W  = 7;
	localparam int STAT_W = 3;
	localparam int NUM_W  = 15;
	localparam int ZRUN_W = 4;
	localparam int IDX_W  = 2;
	localparam int CFG_W  = 7;
	localparam int OFF_W  = 7;

	localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

	localparam logic [IDX_W-1:0] REG_CURVE_MODE   = 2'd0;
	localparam logic [IDX_W-1:0] REG_FULL_LEVEL   = 2'd1;
	localparam logic [IDX_W-1:0] REG_ZERO_CONFIRM = 2'd2;

	localparam logic [PCT_W-1:0]  FULL_LEVEL_RST   = 7'd95;
	localparam logic [ZRUN_W-1:0] ZERO_CONFIRM_RST = 4'd3;

	typedef enum logic [STAT_W-1:0] {
		ST_UNKNOWN      = 3'd0,
		ST_CHARGING     = 3'd1,
		ST_NOT_CHARGING = 3'd2,
		ST_DISCHARGING  = 3'd3,
		ST_FULL         = 3'd4
	} status_t;

	typedef struct packed {
		logic              curve_mode;
		logic [PCT_W-1:0]  full_level;
		logic [ZRUN_W-1:0] zero_confirm;
	} cfg_t;

	typedef struct packed {
		logic known;
		logic present;
		logic active;
	} flags_t;

	// percent = num / 100 + offset, clamped
	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [OFF_W-1:0] offset;
	} curve_t;

endpackage

// ===== rtl/fgs_if.sv =====
interface fgs_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] volt_high;
	logic [7:0] volt_low;
	logic [7:0] charge_high;
	logic [7:0] charge_low;
	logic       charger_known;
	logic       charger_present;
	logic       charger_active;
	logic       battery_present;

	modport source (
		output valid, volt_high, volt_low, charge_high, charge_low,
		output charger_known, charger_present, charger_active, battery_present,
		input  ready
	);
	modport sink (
		input  valid, volt_high, volt_low, charge_high, charge_low,
		input  charger_known, charger_present, charger_active, battery_present,
		output ready
	);
endinterface

interface fgs_out_if;
	logic                        valid;
	logic                        ready;
	logic [fgs_pkg::VOLT_W-1:0]  cell_microvolts;
	logic [fgs_pkg::PCT_W-1:0]   charge_percent;
	logic [fgs_pkg::STAT_W-1:0]  supply_status;
	logic                        online;

	modport source (
		output valid, cell_microvolts, charge_percent, supply_status, online,
		input  ready
	);
	modport sink (
		input  valid, cell_microvolts, charge_percent, supply_status, online,
		output ready
	);
endinterface

interface fgs_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [fgs_pkg::IDX_W-1:0]  index;
	logic [fgs_pkg::CFG_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/fgs_curve.sv =====
module fgs_curve (
	input  logic [7:0]                 volt_high,
	input  logic [7:0]                 volt_low,
	input  logic [7:0]                 charge_high,
	input  logic [7:0]                 charge_low,
	input  logic                       curve_mode,
	output logic [fgs_pkg::VOLT_W-1:0] microvolts,
	output fgs_pkg::curve_t            curve
);
	import fgs_pkg::*;

	localparam logic [VOLT_W-1:0] VOLT_LSB_UV  = 23'd1250;
	localparam logic [NUM_W-1:0]  CHARGE_SCALE = 15'd100;
	// floor(x / 3) = (x * RECIP3) >> 17 for x below 6000
	localparam logic [15:0] RECIP3    = 16'd43691;
	// floor(x * 4 / 5) = (x * RECIP45) >> 17 for x below 18000
	localparam logic [16:0] RECIP45   = 17'd104858;
	// floor(x * 865 / 874) = (x * RECIP_ALT) >> 25 over the whole raw range
	localparam logic [25:0] RECIP_ALT = 26'd33208906;

	logic [11:0]      code;
	logic [NUM_W-1:0] cl_scaled;
	logic [NUM_W-1:0] raw;

	logic [NUM_W-1:0] adj_d;
	logic [12:0]      n_low;
	logic [28:0]      p_low;
	logic [NUM_W-1:0] d_high;
	logic [31:0]      p_high;

	logic [NUM_W-1:0] t_alt;
	logic [40:0]      p_alt;
	logic [NUM_W-1:0] adj_hi;
	logic [NUM_W-1:0] u_diff;
	logic [13:0]      p_mid;
	logic [NUM_W-1:0] adj_a;

	assign code       = {volt_high, volt_low[7:4]};
	assign microvolts = VOLT_W'(code) * VOLT_LSB_UV;

	assign cl_scaled = NUM_W'(charge_low) * CHARGE_SCALE;
	assign raw       = NUM_W'(charge_high) * CHARGE_SCALE + NUM_W'(cl_scaled[14:8]);

	// default curve
	always_comb begin
		priority if (raw >= 15'd100) begin
			adj_d = raw;
		end else if (raw >= 15'd70) begin
			adj_d = 15'd100;
		end else begin
			adj_d = '0;
		end
	end

	assign n_low  = {adj_d[10:0], 2'b00};
	assign p_low  = 29'(n_low) * 29'(RECIP3);
	assign d_high = adj_d - 15'd7600;
	assign p_high = 32'(d_high) * 32'(RECIP45);

	// alternate curve
	assign t_alt  = raw - 15'd460;
	assign p_alt  = 41'(t_alt) * 41'(RECIP_ALT);
	assign adj_hi = p_alt[39:25] + 15'd1350;
	assign u_diff = raw - 15'd60;
	assign p_mid  = 14'(u_diff[8:0]) * 14'd27;

	always_comb begin
		priority if (raw >= 15'd460) begin
			adj_a = adj_hi;
		end else begin
			adj_a = NUM_W'(p_mid[13:3]);
		end
		if (adj_a < 15'd100) begin
			adj_a = 15'd100;
		end
	end

	always_comb begin
		curve = '0;
		if (curve_mode) begin
			priority if (raw < 15'd60) begin
				curve.num = 15'd50;
			end else begin
				curve.num = adj_a + 15'd50;
			end
		end else begin
			priority if (adj_d < 15'd1500) begin
				curve.num = NUM_W'(p_low[28:17]) + 15'd50;
			end else if (adj_d < 15'd7600) begin
				curve.num    = adj_d;
				curve.offset = 7'd5;
			end else begin
				curve.num    = p_high[31:17] + 15'd50;
				curve.offset = 7'd81;
			end
		end
	end

endmodule

// ===== rtl/fgs_resolve.sv =====
`include "fuel_gauge_soc_and_status_top_macros.svh"

module fgs_resolve (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      advance,
	input  fgs_pkg::cfg_t             cfg,
	input  fgs_pkg::curve_t           curve,
	input  fgs_pkg::flags_t           flags,
	output logic [fgs_pkg::PCT_W-1:0] percent,
	output fgs_pkg::status_t          status
);
	import fgs_pkg::*;

	// floor(x / 100) = (x * RECIP100) >> 22 for 15-bit x
	localparam logic [15:0] RECIP100 = 16'd41944;

	logic [ZRUN_W-1:0] zero_run_q;
	logic [PCT_W-1:0]  last_percent_q;

	logic [30:0]       p100;
	logic [8:0]        base;
	logic [PCT_W-1:0]  pct0;
	logic [ZRUN_W-1:0] zr_inc;
	logic [ZRUN_W-1:0] zr_next;

	assign p100 = 31'(curve.num) * 31'(RECIP100);
	assign base = p100[30:22] + 9'(curve.offset);
	assign pct0 = (base > 9'(PCT_MAX)) ? PCT_MAX : base[PCT_W-1:0];

	assign zr_inc = (zero_run_q == '1) ? zero_run_q : zero_run_q + 4'd1;

	// zero debounce in alternate mode
	always_comb begin
		percent = pct0;
		zr_next = zero_run_q;
		if (cfg.curve_mode) begin
			if (pct0 == '0) begin
				if (zr_inc >= cfg.zero_confirm) begin
					zr_next = '0;
				end else begin
					percent = last_percent_q;
					zr_next = zr_inc;
				end
			end else begin
				zr_next = '0;
			end
		end
	end

	always_comb begin
		priority if (!flags.known) begin
			status = ST_UNKNOWN;
		end else if (percent > cfg.full_level) begin
			status = ST_FULL;
		end else if (!flags.present) begin
			status = ST_DISCHARGING;
		end else if (flags.active) begin
			status = ST_CHARGING;
		end else begin
			status = ST_NOT_CHARGING;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_run_q     <= '0;
			last_percent_q <= '0;
		end else if (advance && cfg.curve_mode) begin
			zero_run_q     <= zr_next;
			last_percent_q <= percent;
		end
	end

	`FGS_ASSERT_NEXT(a_last_tracks, clk, arst_n, advance && cfg.curve_mode, last_percent_q == $past(percent), "last percent does not follow reported word")
	`FGS_ASSERT_NEXT(a_default_holds_run, clk, arst_n, advance && !cfg.curve_mode, zero_run_q == $past(zero_run_q), "zero run changed in default mode")
	`FGS_ASSERT_NOW(a_last_in_range, clk, arst_n, 1'b1, last_percent_q <= PCT_MAX, "stored percent above full scale")

endmodule

// ===== rtl/fuel_gauge_soc_and_status_top.sv =====
// Gauge sample decoder. Each sample word gives one result word: cell voltage in
// microvolts, state of charge in whole percent (default or alternate curve, the
// alternate one holding the last value until a run of zero readings confirms
// zero), a supply status code and the battery presence flag. The block takes
// one sample every cycle while its input is ready, and passes it through
// an input register, a stage that forms the raw charge and runs the curve
// multiply, and a stage that divides by 100, applies the zero debounce and
// derives the status into the result register. A result is held until taken;
// behind it up to two more samples fill the pipeline before the input stalls.
// Register writes are taken every cycle and belong to times when no sample is
// in flight.
`include "fuel_gauge_soc_and_status_top_macros.svh"

module fuel_gauge_soc_and_status_top (
	input  logic       clk,
	input  logic       arst_n,
	fgs_cfg_if.sink    cfg,
	fgs_in_if.sink     sample,
	fgs_out_if.source  result
);
	import fgs_pkg::*;

	cfg_t cfg_q;

	logic       valid_s1;
	logic [7:0] volt_high_s1;
	logic [7:0] volt_low_s1;
	logic [7:0] charge_high_s1;
	logic [7:0] charge_low_s1;
	flags_t     flags_s1;
	logic       online_s1;

	logic              valid_s2;
	curve_t            curve_s2;
	logic [VOLT_W-1:0] microvolts_s2;
	flags_t            flags_s2;
	logic              online_s2;

	logic              valid_s3;
	logic [VOLT_W-1:0] microvolts_s3;
	logic [PCT_W-1:0]  percent_s3;
	status_t           status_s3;
	logic              online_s3;

	logic              adv1;
	logic              adv2;
	logic              take_in;
	curve_t            curve_c;
	logic [VOLT_W-1:0] microvolts_c;
	logic [PCT_W-1:0]  percent_c;
	status_t           status_c;

	assign adv2         = valid_s2 && (!valid_s3 || result.ready);
	assign adv1         = valid_s1 && (!valid_s2 || adv2);
	assign sample.ready = !valid_s1 || adv1;
	assign take_in      = sample.valid && sample.ready;
	assign cfg.ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.curve_mode   <= 1'b0;
			cfg_q.full_level   <= FULL_LEVEL_RST;
			cfg_q.zero_confirm <= ZERO_CONFIRM_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_CURVE_MODE:   cfg_q.curve_mode   <= cfg.data[0];
				REG_FULL_LEVEL:   cfg_q.full_level   <= cfg.data;
				REG_ZERO_CONFIRM: cfg_q.zero_confirm <= cfg.data[ZRUN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (sample.ready) begin
				valid_s1 <= sample.valid;
			end
			if (!valid_s2 || adv2) begin
				valid_s2 <= adv1;
			end
			if (!valid_s3 || result.ready) begin
				valid_s3 <= adv2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			volt_high_s1     <= sample.volt_high;
			volt_low_s1      <= sample.volt_low;
			charge_high_s1   <= sample.charge_high;
			charge_low_s1    <= sample.charge_low;
			flags_s1.known   <= sample.charger_known;
			flags_s1.present <= sample.charger_present;
			flags_s1.active  <= sample.charger_active;
			online_s1        <= sample.battery_present;
		end
		if (adv1) begin
			curve_s2      <= curve_c;
			microvolts_s2 <= microvolts_c;
			flags_s2      <= flags_s1;
			online_s2     <= online_s1;
		end
		if (adv2) begin
			microvolts_s3 <= microvolts_s2;
			percent_s3    <= percent_c;
			status_s3     <= status_c;
			online_s3     <= online_s2;
		end
	end

	fgs_curve u_curve (
		.volt_high   (volt_high_s1),
		.volt_low    (volt_low_s1),
		.charge_high (charge_high_s1),
		.charge_low  (charge_low_s1),
		.curve_mode  (cfg_q.curve_mode),
		.microvolts  (microvolts_c),
		.curve       (curve_c)
	);

	fgs_resolve u_resolve (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (adv2),
		.cfg     (cfg_q),
		.curve   (curve_s2),
		.flags   (flags_s2),
		.percent (percent_c),
		.status  (status_c)
	);

	assign result.valid           = valid_s3;
	assign result.cell_microvolts = microvolts_s3;
	assign result.charge_percent  = percent_s3;
	assign result.supply_status   = status_s3;
	assign result.online          = online_s3;

	`FGS_ASSERT_NOW(a_pct_range, clk, arst_n, result.valid, result.charge_percent <= PCT_MAX, "result percent above full scale")
	`FGS_ASSERT_NOW(a_full_nonzero, clk, arst_n, result.valid && (result.supply_status == ST_FULL), result.charge_percent != '0, "full status with zero percent")
	`FGS_ASSERT_NOW(a_empty_takes, clk, arst_n, !valid_s1, sample.ready, "input stage empty but not ready")

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import fgs_pkg::*;

	typedef struct {
		logic [7:0] volt_high;
		logic [7:0] volt_low;
		logic [7:0] charge_high;
		logic [7:0] charge_low;
		logic       charger_known;
		logic       charger_present;
		logic       charger_active;
		logic       battery_present;
	} sample_t;

	typedef struct {
		logic [VOLT_W-1:0] microvolts;
		logic [PCT_W-1:0]  percent;
		status_t           status;
		logic              online;
	} reading_t;

	logic clk;
	logic arst_n;

	fgs_cfg_if cfg_bus();
	fgs_in_if  sample_bus();
	fgs_out_if result_bus();

	fuel_gauge_soc_and_status_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.sample (sample_bus),
		.result (result_bus)
	);

	// shadow registers and debounce state
	logic              mode_q;
	logic [PCT_W-1:0]  full_q;
	logic [ZRUN_W-1:0] confirm_q;
	logic [ZRUN_W-1:0] zero_run_q;
	logic [PCT_W-1:0]  last_pct_q;

	reading_t pending_readings[$];
	int       errors;
	int       n_samples;
	int       n_checked;
	int       n_writes;
	int       n_zero_held;
	bit       rush;

	initial begin
		clk = 1'b0;
	end

	always #4 clk = ~clk;

	function automatic logic [PCT_W-1:0] default_soc(input int unsigned raw);
		int unsigned adj;
		int unsigned pct;
		if (raw >= 100) begin
			adj = raw;
		end else if (raw >= 70) begin
			adj = 100;
		end else begin
			adj = 0;
		end
		if (adj < 1500) begin
			pct = (adj * 4 / 3 + 50) / 100;
		end else if (adj < 7600) begin
			pct = adj / 100 + 5;
		end else begin
			pct = ((adj - 7600) * 8 / 10 + 50) / 100 + 81;
		end
		return (pct > 100) ? PCT_MAX : pct[PCT_W-1:0];
	endfunction

	function automatic logic [PCT_W-1:0] alternate_soc(input int unsigned raw);
		int unsigned adj;
		int unsigned pct;
		if (raw >= 60) begin
			if (raw >= 460) begin
				adj = (raw - 460) * 8650 / 8740 + 1350;
			end else begin
				adj = (raw - 60) * 1350 / 400;
			end
			if (adj < 100) begin
				adj = 100;
			end
		end else begin
			adj = 0;
		end
		pct = adj / 100;
		if (adj % 100 >= 50) begin
			pct = pct + 1;
		end
		return (pct > 100) ? PCT_MAX : pct[PCT_W-1:0];
	endfunction

	// updates the debounce state as the block does
	function automatic reading_t decode_sample(input sample_t s);
		reading_t    r;
		int unsigned code;
		int unsigned raw;
		logic [PCT_W-1:0] pct;
		code = 32'({s.volt_high, s.volt_low[7:4]});
		raw = s.charge_high * 100 + (s.charge_low * 100) / 256;
		r.microvolts = VOLT_W'(code * 1250);
		if (!mode_q) begin
			pct = default_soc(raw);
		end else begin
			pct = alternate_soc(raw);
			if (pct == 0) begin
				if (zero_run_q < 15) begin
					zero_run_q = zero_run_q + 1'b1;
				end
				if (zero_run_q >= confirm_q) begin
					zero_run_q = '0;
				end else begin
					pct = last_pct_q;
					n_zero_held++;
				end
			end else begin
				zero_run_q = '0;
			end
			last_pct_q = pct;
		end
		if (!s.charger_known) begin
			r.status = ST_UNKNOWN;
		end else begin
			if (s.charger_present) begin
				r.status = s.charger_active ? ST_CHARGING : ST_NOT_CHARGING;
			end else begin
				r.status = ST_DISCHARGING;
			end
			if (pct > full_q) begin
				r.status = ST_FULL;
			end
		end
		r.percent = pct;
		r.online = s.battery_present;
		return r;
	endfunction

	function automatic sample_t make_sample(input logic [7:0] vh, input logic [7:0] vl,
			input logic [7:0] ch, input logic [7:0] cl, input logic [3:0] flags);
		sample_t s;
		s.volt_high = vh;
		s.volt_low = vl;
		s.charge_high = ch;
		s.charge_low = cl;
		{s.charger_known, s.charger_present, s.charger_active, s.battery_present} = flags;
		return s;
	endfunction

	function automatic sample_t random_sample(input bit low_charge);
		sample_t s;
		s = make_sample(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			4'($urandom));
		if (low_charge) begin
			s.charge_high = '0;
			s.charge_low = 8'($urandom_range(0, 153));
		end else begin
			case ($urandom_range(0, 3))
				0: s.charge_high = 8'($urandom_range(0, 4));
				1: s.charge_high = 8'($urandom_range(14, 16));
				2: s.charge_high = 8'($urandom_range(74, 101));
				default: ;
			endcase
		end
		return s;
	endfunction

	task automatic send_sample(input sample_t s);
		int gap;
		gap = rush ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			sample_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_bus.valid <= 1'b1;
		sample_bus.volt_high <= s.volt_high;
		sample_bus.volt_low <= s.volt_low;
		sample_bus.charge_high <= s.charge_high;
		sample_bus.charge_low <= s.charge_low;
		sample_bus.charger_known <= s.charger_known;
		sample_bus.charger_present <= s.charger_present;
		sample_bus.charger_active <= s.charger_active;
		sample_bus.battery_present <= s.battery_present;
		do @(posedge clk); while (!sample_bus.ready);
		pending_readings.push_back(decode_sample(s));
		n_samples++;
	endtask

	task automatic drain_readings();
		sample_bus.valid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= value;
		do @(posedge clk); while (!cfg_bus.ready);
		case (idx)
			REG_CURVE_MODE:   mode_q = value[0];
			REG_FULL_LEVEL:   full_q = value[PCT_W-1:0];
			REG_ZERO_CONFIRM: confirm_q = value[ZRUN_W-1:0];
			default: ;
		endcase
		n_writes++;
	endtask

	task automatic set_config(input logic mode, input logic [PCT_W-1:0] full,
			input logic [ZRUN_W-1:0] confirm);
		drain_readings();
		write_reg(REG_CURVE_MODE, CFG_W'(mode));
		write_reg(REG_FULL_LEVEL, CFG_W'(full));
		write_reg(REG_ZERO_CONFIRM, CFG_W'(confirm));
		cfg_bus.valid <= 1'b0;
	endtask

	// reset settings, default curve breakpoints and flag combinations
	task automatic test_default_curve();
		send_sample(make_sample(8'h00, 8'h00, 8'd0, 8'd0, 4'b0000));
		send_sample(make_sample(8'hFF, 8'hFF, 8'd255, 8'd255, 4'b1111));
		send_sample(make_sample(8'h80, 8'h0F, 8'd0, 8'd177, 4'b1101));
		send_sample(make_sample(8'h01, 8'hF0, 8'd0, 8'd180, 4'b1011));
		send_sample(make_sample(8'h7F, 8'h10, 8'd0, 8'd254, 4'b1110));
		send_sample(make_sample(8'hAA, 8'h55, 8'd1, 8'd0, 4'b0111));
		send_sample(make_sample(8'h55, 8'hAA, 8'd14, 8'd254, 4'b1100));
		send_sample(make_sample(8'hC3, 8'h3C, 8'd15, 8'd0, 4'b1000));
		send_sample(make_sample(8'h3C, 8'hC3, 8'd75, 8'd254, 4'b1010));
		send_sample(make_sample(8'h12, 8'h34, 8'd76, 8'd0, 4'b1001));
		send_sample(make_sample(8'hFE, 8'hE0, 8'd99, 8'd0, 4'b1100));
		send_sample(make_sample(8'h00, 8'hFF, 8'd100, 8'd0, 4'b1111));
	endtask

	// alternate curve breakpoints and the zero debounce
	task automatic test_zero_debounce();
		set_config(1'b1, 7'd95, 4'd3);
		send_sample(make_sample(8'h40, 8'h00, 8'd0, 8'd154, 4'b1110));
		send_sample(make_sample(8'h40, 8'h00, 8'd0, 8'd152, 4'b1110));
		send_sample(make_sample(8'h40, 8'h00, 8'd0, 8'd0, 4'b1100));
		send_sample(make_sample(8'h40, 8'h00, 8'd0, 8'd100, 4'b1101));
		send_sample(make_sample(8'h40, 8'h00, 8'd4, 8'd154, 4'b1111));
		send_sample(make_sample(8'h40, 8'h00, 8'd4, 8'd254, 4'b1011));
		send_sample(make_sample(8'h40, 8'h00, 8'd255, 8'd255, 4'b1111));
		// zero confirm of zero and one, full level extremes
		set_config(1'b1, 7'd127, 4'd0);
		send_sample(make_sample(8'h22, 8'h20, 8'd0, 8'd0, 4'b1111));
		send_sample(make_sample(8'h22, 8'h20, 8'd255, 8'd0, 4'b1111));
		set_config(1'b1, 7'd0, 4'd1);
		send_sample(make_sample(8'h22, 8'h20, 8'd0, 8'd1, 4'b1101));
		send_sample(make_sample(8'h22, 8'h20, 8'd0, 8'd154, 4'b1101));
		set_config(1'b0, 7'd100, 4'd15);
		send_sample(make_sample(8'h22, 8'h20, 8'd255, 8'd255, 4'b1110));
	endtask

	task automatic test_random_phases(input int phases, input int per_phase);
		int count;
		int run;
		logic [PCT_W-1:0] full;
		logic [ZRUN_W-1:0] confirm;
		for (int p = 0; p < phases; p++) begin
			case ($urandom_range(0, 4))
				0: full = 7'd0;
				1: full = 7'd100;
				2: full = 7'd127;
				default: full = 7'($urandom_range(0, 127));
			endcase
			case ($urandom_range(0, 4))
				0: confirm = 4'd0;
				1: confirm = 4'd1;
				2: confirm = 4'd15;
				default: confirm = 4'($urandom_range(0, 15));
			endcase
			set_config(p[0] ^ (p >= phases / 2), full, confirm);
			rush = ($urandom_range(0, 3) == 0);
			count = 0;
			while (count < per_phase) begin
				if ($urandom_range(0, 2) == 0) begin
					run = $urandom_range(1, 18);
					repeat (run) send_sample(random_sample(1'b1));
				end else begin
					run = $urandom_range(1, 6);
					repeat (run) send_sample(random_sample(1'b0));
				end
				count += run;
			end
			rush = 1'b0;
		end
	endtask

	task automatic report(input string field, input int unsigned exp_v, input int unsigned act_v);
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
		errors++;
	endtask

	// result side: random stalls, then compare each word with the oldest prediction
	initial begin
		reading_t exp_r;
		int stall;
		result_bus.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = rush ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				result_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_bus.ready <= 1'b1;
			do @(posedge clk); while (!result_bus.valid);
			if (pending_readings.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %0d uV %0d%%",
					$time, result_bus.cell_microvolts, result_bus.charge_percent);
				errors++;
			end else begin
				exp_r = pending_readings.pop_front();
				n_checked++;
				if (result_bus.cell_microvolts !== exp_r.microvolts)
					report("cell_microvolts", 32'(exp_r.microvolts),
						32'(result_bus.cell_microvolts));
				if (result_bus.charge_percent !== exp_r.percent)
					report("charge_percent", 32'(exp_r.percent),
						32'(result_bus.charge_percent));
				if (result_bus.supply_status !== exp_r.status)
					report("supply_status", 32'(exp_r.status),
						32'(result_bus.supply_status));
				if (result_bus.online !== exp_r.online)
					report("online", 32'(exp_r.online), 32'(result_bus.online));
			end
		end
	end

	initial begin
		int waited;
		errors = 0;
		n_samples = 0;
		n_checked = 0;
		n_writes = 0;
		n_zero_held = 0;
		rush = 1'b0;
		mode_q = 1'b0;
		full_q = FULL_LEVEL_RST;
		confirm_q = ZERO_CONFIRM_RST;
		zero_run_q = '0;
		last_pct_q = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data = '0;
		sample_bus.valid = 1'b0;
		sample_bus.volt_high = '0;
		sample_bus.volt_low = '0;
		sample_bus.charge_high = '0;
		sample_bus.charge_low = '0;
		sample_bus.charger_known = 1'b0;
		sample_bus.charger_present = 1'b0;
		sample_bus.charger_active = 1'b0;
		sample_bus.battery_present = 1'b0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_curve();
		test_zero_debounce();
		test_random_phases(10, 128);

		sample_bus.valid <= 1'b0;
		waited = 0;
		while (pending_readings.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (pending_readings.size() != 0) begin
			$display("%0t: %0d results missing, expected %0d uV %0d%%", $time,
				pending_readings.size(), pending_readings[0].microvolts,
				pending_readings[0].percent);
			errors++;
		end
		$display("summary: %0d samples sent, %0d results checked, %0d register writes",
			n_samples, n_checked, n_writes);
		$display("summary: %0d zero readings held by debounce", n_zero_held);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("timeout at %0t", $time);
		$display("DONE: errors detected");
		$finish;
	end

endmodule
